// ----- rtl/framed_crc_ring_log_buffer_macros.svh -----
// Assertion macros for the framed CRC ring log buffer checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FRAMED_CRC_RING_LOG_BUFFER_MACROS_SVH
`define FRAMED_CRC_RING_LOG_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCLB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fclb assertion failed");

// Next-cycle implication, disabled during reset.
`define FCLB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fclb assertion failed");

`endif

// ----- rtl/fclb_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the ring log buffer.
// No dependencies.
package fclb_pkg;

    localparam int BODY_BYTES = 4096;
    localparam int RING_AW    = 12;
    localparam int HEAD_BYTES = 4;
    localparam int MAX_ENTRY  = 256;
    localparam int STG_AW     = 8;
    localparam int STG_LW     = 9;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_OVF    = 2'd3;

    localparam logic [7:0] CFG_CRC_POLY     = 8'd0;
    localparam logic [7:0] CFG_ENTRY_MARKER = 8'd1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_STAGE_WR,
        OP_STAGE_OVF,
        OP_CLEAR,
        OP_REJECT,
        OP_SKIP_OPEN,
        OP_DROP_BEGIN,
        OP_RP_TO_WP,
        OP_HDR_START,
        OP_HDR_STEP,
        OP_ADV1,
        OP_ADV1_DMG,
        OP_ADV4,
        OP_DROP_HDR,
        OP_ADV_LEN1,
        OP_BODY_START,
        OP_BODY_STEP,
        OP_OPEN,
        OP_RD_ISSUE,
        OP_RD_TAKE,
        OP_NO_DATA,
        OP_CM_START,
        OP_CM_LEN,
        OP_CM_HCRC,
        OP_CM_BODY,
        OP_CM_BCRC,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RS_CHK,
        S_HDR_RUN,
        S_RS_HEVAL,
        S_RS_BCHK,
        S_BODY_RUN,
        S_RS_BEVAL,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_CM_CHECK,
        S_CM_ROOM,
        S_DR_CHK,
        S_DR_HEVAL,
        S_DR_BCHK,
        S_DR_BEVAL,
        S_CM_START,
        S_CM_LEN,
        S_CM_HCRC,
        S_CM_BODY,
        S_CM_BCRC,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       in_last;
        logic       stg_full;
        logic       oversize;
        logic       room_short;
        logic       rem_zero;
        logic       occ_zero;
        logic       occ_le_head;
        logic       hdr_good;
        logic       damaged;
        logic       hdr_last;
        logic       body_last;
        logic       body_short;
        logic       body_good;
        logic       len_zero;
        logic       cm_len_last;
        logic       cm_body_last;
    } dp_status_t;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/fclb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fclb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/fclb_ctrl.sv -----
// Sequencer for the ring log buffer: walks append, commit, drop and read scans.
// Depends on fclb_pkg; drives fclb_dpath through dp_cmd_t, reads dp_status_t.
module fclb_ctrl
    import fclb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   mode_reg, mode_next;      // 1: header/body run belongs to a drop
    logic   oval_reg, oval_next;
    logic   emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            oval_reg  <= oval_next;
        end
    end

    assign emit      = (state_reg == S_RESP) && (!oval_reg || m_tready);
    assign oval_next = emit ? 1'b1 : (m_tready ? 1'b0 : oval_reg);
    assign m_tvalid  = oval_reg;
    assign s_tready  = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (st.req)
                    REQ_APPEND: state_next = (!st.stg_full && st.in_last) ? S_CM_CHECK : S_RESP;
                    REQ_READ:   state_next = S_RS_CHK;
                    REQ_CLEAR:  state_next = S_RESP;
                    REQ_NONE:   state_next = S_RESP;
                endcase
            end
            S_RS_CHK:
            begin
                priority if (!st.rem_zero)
                    state_next = S_RD_ISSUE;
                else if (st.occ_zero)
                    state_next = S_RESP;
                else if (st.occ_le_head)
                    state_next = S_RS_CHK;
                else
                begin
                    state_next = S_HDR_RUN;
                    mode_next  = 1'b0;
                end
            end
            S_HDR_RUN:
            begin
                if (st.hdr_last)
                begin
                    state_next = mode_reg ? S_DR_HEVAL : S_RS_HEVAL;
                end
            end
            S_RS_HEVAL: state_next = st.hdr_good ? S_RS_BCHK : S_RS_CHK;
            S_RS_BCHK:  state_next = st.body_short ? S_RS_CHK : S_BODY_RUN;
            S_BODY_RUN:
            begin
                if (st.body_last)
                begin
                    state_next = mode_reg ? S_DR_BEVAL : S_RS_BEVAL;
                end
            end
            S_RS_BEVAL:
            begin
                state_next = (st.body_good && !st.len_zero) ? S_RD_ISSUE : S_RS_CHK;
            end
            S_RD_ISSUE: state_next = S_RD_TAKE;
            S_RD_TAKE:  state_next = S_RESP;
            S_CM_CHECK: state_next = st.oversize ? S_RESP : S_CM_ROOM;
            S_CM_ROOM:
            begin
                priority if (!st.room_short)
                    state_next = S_CM_START;
                else if (!st.rem_zero)
                    state_next = S_CM_ROOM;
                else
                    state_next = S_DR_CHK;
            end
            S_DR_CHK:
            begin
                priority if (st.occ_zero || st.occ_le_head)
                    state_next = S_CM_ROOM;
                else
                begin
                    state_next = S_HDR_RUN;
                    mode_next  = 1'b1;
                end
            end
            S_DR_HEVAL:
            begin
                priority if (!st.hdr_good)
                    state_next = S_DR_CHK;
                else if (st.damaged)
                    state_next = S_CM_ROOM;
                else
                    state_next = S_DR_BCHK;
            end
            S_DR_BCHK:  state_next = st.body_short ? S_CM_ROOM : S_BODY_RUN;
            S_DR_BEVAL: state_next = S_CM_ROOM;
            S_CM_START: state_next = S_CM_LEN;
            S_CM_LEN:   state_next = st.cm_len_last ? S_CM_HCRC : S_CM_LEN;
            S_CM_HCRC:  state_next = S_CM_BODY;
            S_CM_BODY:  state_next = st.cm_body_last ? S_CM_BCRC : S_CM_BODY;
            S_CM_BCRC:  state_next = S_RESP;
            S_RESP:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd.op = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = OP_LATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (st.req)
                    REQ_APPEND: cmd.op = st.stg_full ? OP_STAGE_OVF : OP_STAGE_WR;
                    REQ_READ:   cmd.op = OP_NOP;
                    REQ_CLEAR:  cmd.op = OP_CLEAR;
                    REQ_NONE:   cmd.op = OP_NOP;
                endcase
            end
            S_RS_CHK:
            begin
                priority if (!st.rem_zero)
                    cmd.op = OP_NOP;
                else if (st.occ_zero)
                    cmd.op = OP_NO_DATA;
                else if (st.occ_le_head)
                    cmd.op = OP_RP_TO_WP;
                else
                    cmd.op = OP_HDR_START;
            end
            S_HDR_RUN:  cmd.op = OP_HDR_STEP;
            S_RS_HEVAL: cmd.op = st.hdr_good ? OP_ADV4 : OP_ADV1;
            S_RS_BCHK:  cmd.op = st.body_short ? OP_NOP : OP_BODY_START;
            S_BODY_RUN: cmd.op = OP_BODY_STEP;
            S_RS_BEVAL:
            begin
                priority if (!st.body_good)
                    cmd.op = OP_NOP;
                else if (st.len_zero)
                    cmd.op = OP_ADV1;
                else
                    cmd.op = OP_OPEN;
            end
            S_RD_ISSUE: cmd.op = OP_RD_ISSUE;
            S_RD_TAKE:  cmd.op = OP_RD_TAKE;
            S_CM_CHECK: cmd.op = st.oversize ? OP_REJECT : OP_NOP;
            S_CM_ROOM:
            begin
                priority if (!st.room_short)
                    cmd.op = OP_NOP;
                else if (!st.rem_zero)
                    cmd.op = OP_SKIP_OPEN;
                else
                    cmd.op = OP_DROP_BEGIN;
            end
            S_DR_CHK:
            begin
                priority if (st.occ_zero)
                    cmd.op = OP_NOP;
                else if (st.occ_le_head)
                    cmd.op = OP_RP_TO_WP;
                else
                    cmd.op = OP_HDR_START;
            end
            S_DR_HEVAL:
            begin
                priority if (!st.hdr_good)
                    cmd.op = OP_ADV1_DMG;
                else if (st.damaged)
                    cmd.op = OP_NOP;
                else
                    cmd.op = OP_DROP_HDR;
            end
            S_DR_BCHK:  cmd.op = st.body_short ? OP_NOP : OP_BODY_START;
            S_DR_BEVAL: cmd.op = st.body_good ? OP_ADV_LEN1 : OP_NOP;
            S_CM_START: cmd.op = OP_CM_START;
            S_CM_LEN:   cmd.op = OP_CM_LEN;
            S_CM_HCRC:  cmd.op = OP_CM_HCRC;
            S_CM_BODY:  cmd.op = OP_CM_BODY;
            S_CM_BCRC:  cmd.op = OP_CM_BCRC;
            S_RESP:     cmd.op = emit ? OP_EMIT : OP_NOP;
        endcase
    end

endmodule

// ----- rtl/fclb_dpath.sv -----
// Datapath: pointers, counters, CRC unit, staging and ring RAMs, result register.
// Depends on fclb_pkg and fclb_ram; commanded by fclb_ctrl.
module fclb_dpath
    import fclb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    output dp_status_t   st,
    input  logic [7:0]   in_byte,
    input  logic [1:0]   in_req,
    input  logic         in_last,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_idx,
    input  logic [7:0]   cfg_wdata,
    output logic [7:0]   out_data,
    output logic         out_valid,
    output logic         out_last,
    output logic [1:0]   out_status,
    output logic [31:0]  out_written,
    output logic [31:0]  out_dropped,
    output logic [31:0]  out_wraps,
    output logic [11:0]  out_occ
);

    localparam logic [RING_AW-1:0] WP_LAST = RING_AW'(BODY_BYTES - 1);

    // Control state
    logic [RING_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [31:0]        wr_reg, wr_next, drop_reg, drop_next, wrap_reg, wrap_next;
    logic [STG_LW-1:0]  stg_len_reg, stg_len_next;
    logic [RING_AW-1:0] rem_reg, rem_next;
    logic               dmg_reg, dmg_next;
    logic [7:0]         poly_reg, marker_reg;

    // Working payload
    logic [RING_AW-1:0] ptr_reg, ptr_next, cnt_reg, cnt_next;
    logic [7:0]         crc_reg, crc_next, b0_reg, b0_next;
    logic [15:0]        len_reg, len_next;
    logic [1:0]         req_reg, req_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic [7:0]         res_data_reg, res_data_next;
    logic               res_valid_reg, res_valid_next, res_last_reg, res_last_next;
    logic [1:0]         res_stat_reg, res_stat_next;

    // RAM ports
    logic               ring_we;
    logic [RING_AW-1:0] ring_raddr;
    logic [7:0]         ring_wdata, ring_rdata;
    logic [STG_AW-1:0]  stg_raddr;
    logic [7:0]         stg_rdata;
    logic               stg_we;

    logic [RING_AW-1:0] occ;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    fclb_ram #(.WIDTH(8), .DEPTH(BODY_BYTES)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    fclb_ram #(.WIDTH(8), .DEPTH(MAX_ENTRY)) u_stage (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_len_reg[STG_AW-1:0]),
        .wdata (byte_reg),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    assign occ = wp_reg - rp_reg;

    always_comb
    begin
        st.req          = req_reg;
        st.in_last      = last_reg;
        st.stg_full     = (stg_len_reg == STG_LW'(MAX_ENTRY));
        st.oversize     = (13'(stg_len_reg) + 13'(HEAD_BYTES + 1)) > 13'(BODY_BYTES - 1);
        st.room_short   = ((13'(stg_len_reg) + 13'(HEAD_BYTES + 1) + 13'(occ))
                           > 13'(BODY_BYTES - 1)) && (occ != '0);
        st.rem_zero     = (rem_reg == '0);
        st.occ_zero     = (occ == '0);
        st.occ_le_head  = (occ <= RING_AW'(HEAD_BYTES));
        st.hdr_good     = (b0_reg == marker_reg) && (crc_reg == 8'd0);
        st.damaged      = dmg_reg;
        st.hdr_last     = (cnt_reg == RING_AW'(HEAD_BYTES - 1));
        st.body_last    = (16'(cnt_reg) == len_reg);
        st.body_short   = 17'(occ) < (17'(len_reg) + 17'd1);
        st.body_good    = (crc_reg == 8'd0);
        st.len_zero     = (len_reg == 16'd0);
        st.cm_len_last  = (cnt_reg == RING_AW'(1));
        st.cm_body_last = (cnt_reg == (RING_AW'(stg_len_reg) - RING_AW'(1)));
    end

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        wr_next        = wr_reg;
        drop_next      = drop_reg;
        wrap_next      = wrap_reg;
        stg_len_next   = stg_len_reg;
        rem_next       = rem_reg;
        dmg_next       = dmg_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        b0_next        = b0_reg;
        len_next       = len_reg;
        req_next       = req_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg;
        res_last_next  = res_last_reg;
        res_stat_next  = res_stat_reg;
        ring_we        = 1'b0;
        ring_wdata     = 8'd0;
        ring_raddr     = ptr_reg;
        stg_we         = 1'b0;
        stg_raddr      = cnt_reg[STG_AW-1:0] + STG_AW'(1);

        unique case (cmd.op)
            OP_NOP: ;
            OP_LATCH:
            begin
                req_next       = in_req;
                byte_next      = in_byte;
                last_next      = in_last;
                res_data_next  = 8'd0;
                res_valid_next = 1'b0;
                res_last_next  = 1'b0;
                res_stat_next  = STAT_OK;
            end
            OP_STAGE_WR:
            begin
                stg_we       = 1'b1;
                stg_len_next = stg_len_reg + STG_LW'(1);
            end
            OP_STAGE_OVF:
            begin
                res_stat_next = STAT_OVF;
                if (last_reg)
                begin
                    stg_len_next = '0;
                end
            end
            OP_CLEAR:
            begin
                drop_next = wr_reg;
                rp_next   = wp_reg;
                rem_next  = '0;
            end
            OP_REJECT:
            begin
                res_stat_next = STAT_REJECT;
                stg_len_next  = '0;
            end
            OP_SKIP_OPEN:
            begin
                rp_next  = rp_reg + rem_reg + RING_AW'(1);
                rem_next = '0;
            end
            OP_DROP_BEGIN: dmg_next = 1'b0;
            OP_RP_TO_WP:   rp_next  = wp_reg;
            OP_HDR_START, OP_BODY_START:
            begin
                ring_raddr = rp_reg;
                ptr_next   = rp_reg + RING_AW'(1);
                cnt_next   = '0;
                crc_next   = 8'd0;
            end
            OP_HDR_STEP:
            begin
                ring_raddr = ptr_reg;
                ptr_next   = ptr_reg + RING_AW'(1);
                cnt_next   = cnt_reg + RING_AW'(1);
                crc_next   = crc8_byte(crc_reg, ring_rdata, poly_reg);
                if (cnt_reg == RING_AW'(0))
                begin
                    b0_next = ring_rdata;
                end
                if (cnt_reg == RING_AW'(1))
                begin
                    len_next[7:0] = ring_rdata;
                end
                if (cnt_reg == RING_AW'(2))
                begin
                    len_next[15:8] = ring_rdata;
                end
            end
            OP_BODY_STEP:
            begin
                ring_raddr = ptr_reg;
                ptr_next   = ptr_reg + RING_AW'(1);
                cnt_next   = cnt_reg + RING_AW'(1);
                crc_next   = crc8_byte(crc_reg, ring_rdata, poly_reg);
            end
            OP_ADV1: rp_next = rp_reg + RING_AW'(1);
            OP_ADV1_DMG:
            begin
                rp_next  = rp_reg + RING_AW'(1);
                dmg_next = 1'b1;
            end
            OP_ADV4: rp_next = rp_reg + RING_AW'(HEAD_BYTES);
            OP_DROP_HDR:
            begin
                rp_next   = rp_reg + RING_AW'(HEAD_BYTES);
                drop_next = sat_inc(drop_reg);
            end
            OP_ADV_LEN1: rp_next  = rp_reg + len_reg[RING_AW-1:0] + RING_AW'(1);
            OP_OPEN:     rem_next = len_reg[RING_AW-1:0];
            OP_RD_ISSUE: ring_raddr = rp_reg;
            OP_RD_TAKE:
            begin
                res_data_next  = ring_rdata;
                res_valid_next = 1'b1;
                res_last_next  = (rem_reg == RING_AW'(1));
                rem_next       = rem_reg - RING_AW'(1);
                // Skip the body CRC byte after the final payload byte.
                rp_next        = rp_reg + ((rem_reg == RING_AW'(1)) ? RING_AW'(2) : RING_AW'(1));
            end
            OP_NO_DATA: res_stat_next = STAT_EMPTY;
            OP_CM_START:
            begin
                ring_we    = 1'b1;
                ring_wdata = marker_reg;
                crc_next   = crc8_byte(8'd0, marker_reg, poly_reg);
                cnt_next   = '0;
            end
            OP_CM_LEN:
            begin
                ring_we    = 1'b1;
                ring_wdata = (cnt_reg == RING_AW'(0)) ? stg_len_reg[7:0]
                                                      : {7'd0, stg_len_reg[8]};
                crc_next   = crc8_byte(crc_reg, ring_wdata, poly_reg);
                cnt_next   = cnt_reg + RING_AW'(1);
            end
            OP_CM_HCRC:
            begin
                ring_we    = 1'b1;
                ring_wdata = crc_reg;
                crc_next   = 8'd0;
                cnt_next   = '0;
                stg_raddr  = '0;
            end
            OP_CM_BODY:
            begin
                ring_we    = 1'b1;
                ring_wdata = stg_rdata;
                crc_next   = crc8_byte(crc_reg, stg_rdata, poly_reg);
                cnt_next   = cnt_reg + RING_AW'(1);
            end
            OP_CM_BCRC:
            begin
                ring_we      = 1'b1;
                ring_wdata   = crc_reg;
                wr_next      = sat_inc(wr_reg);
                stg_len_next = '0;
            end
            OP_EMIT: ;
        endcase

        // Advance the write pointer on every ring write, counting wraps.
        if (ring_we)
        begin
            wp_next = wp_reg + RING_AW'(1);
            if (wp_reg == WP_LAST)
            begin
                wrap_next = sat_inc(wrap_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            wr_reg      <= '0;
            drop_reg    <= '0;
            wrap_reg    <= '0;
            stg_len_reg <= '0;
            rem_reg     <= '0;
            dmg_reg     <= 1'b0;
            poly_reg    <= 8'd7;
            marker_reg  <= 8'd165;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            wr_reg      <= wr_next;
            drop_reg    <= drop_next;
            wrap_reg    <= wrap_next;
            stg_len_reg <= stg_len_next;
            rem_reg     <= rem_next;
            dmg_reg     <= dmg_next;
            if (cfg_we && (cfg_idx == CFG_CRC_POLY))
            begin
                poly_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_idx == CFG_ENTRY_MARKER))
            begin
                marker_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        cnt_reg       <= cnt_next;
        crc_reg       <= crc_next;
        b0_reg        <= b0_next;
        len_reg       <= len_next;
        req_reg       <= req_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        res_data_reg  <= res_data_next;
        res_valid_reg <= res_valid_next;
        res_last_reg  <= res_last_next;
        res_stat_reg  <= res_stat_next;
        if (cmd.op == OP_EMIT)
        begin
            out_data    <= res_data_reg;
            out_valid   <= res_valid_reg;
            out_last    <= res_last_reg;
            out_status  <= res_stat_reg;
            out_written <= wr_reg;
            out_dropped <= drop_reg;
            out_wraps   <= wrap_reg;
            out_occ     <= occ;
        end
    end

endmodule

// ----- rtl/framed_crc_ring_log_buffer.sv -----
// Read scans step through headers and bodies one ring byte per cycle; a commit may first make room.
// Requests are handled one at a time; the ring RAM read port sets the pace of scans.
// Reset: asynchronous, active low; pointers, counters and staging length clear, crc_poly
// takes 7, entry_marker 165; RAM contents are not cleared. Needs fclb_pkg, fclb_ctrl, fclb_dpath.
module framed_crc_ring_log_buffer
    import fclb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Request beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic [1:0]   s_tuser,    // [1:0] req_type
    input  logic         s_tlast,    // last_of_entry
    // Result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,    // [7:0] read_data, [8] read_valid,
                                     // [40:9] entries_written, [72:41] entries_dropped,
                                     // [104:73] wrap_count, [116:105] bytes_occupied
    output logic [1:0]   m_tuser,    // [1:0] status
    output logic         m_tlast,    // read_last
    // Configuration writes: index 0 crc_poly, 1 entry_marker
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    logic [7:0]  out_data;
    logic        out_valid;
    logic [31:0] out_written, out_dropped, out_wraps;
    logic [11:0] out_occ;

    // Configuration is to be written only while idle; the block does not enforce this and always takes it.
    assign cfg_ready = 1'b1;

    fclb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fclb_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_byte     (s_tdata),
        .in_req      (s_tuser),
        .in_last     (s_tlast),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_wdata   (cfg_data),
        .out_data    (out_data),
        .out_valid   (out_valid),
        .out_last    (m_tlast),
        .out_status  (m_tuser),
        .out_written (out_written),
        .out_dropped (out_dropped),
        .out_wraps   (out_wraps),
        .out_occ     (out_occ)
    );

    // Pack the result beat, first field lowest, zero fill to whole bytes.
    assign m_tdata = {3'd0, out_occ, out_wraps, out_dropped, out_written, out_valid, out_data};

endmodule

// ----- rtl/fclb_assert.sv -----
// Port-level checks for the ring log buffer, bound to the top level.
// Depends on framed_crc_ring_log_buffer_macros.svh.
`include "framed_crc_ring_log_buffer_macros.svh"

module fclb_assert (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled result beat stays up.
    `FCLB_ASSERT_NXT(a_hold_result, m_tvalid && !m_tready, m_tvalid)

    // A delivered payload byte always carries ok status.
    `FCLB_ASSERT_IMP(a_valid_ok, m_tvalid && m_tdata[8], m_tuser == 2'd0)

    // The last flag only marks a delivered payload byte.
    `FCLB_ASSERT_IMP(a_last_valid, m_tvalid && m_tlast, m_tdata[8])

endmodule

bind framed_crc_ring_log_buffer fclb_assert u_fclb_assert (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
